>>> rtl/core/csp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    // longest line is LINE_CAPACITY - 1 emitted bytes
    localparam int LINE_CAPACITY = 4096;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       line_done;
        logic       run_last;
    } t_out_item;

    // scanner mode and line state carried from byte to byte
    typedef struct packed {
        logic             in_block_comment;
        logic             in_string_lit;
        logic             in_char_lit;
        logic             skip_rest_of_line;
        logic [7:0]       held_byte;
        logic             held_valid;
        logic [CNT_W-1:0] out_count;
    } t_scan_state;

    // results of one source byte: up to two bytes and the closing marker
    typedef struct packed {
        logic [1:0] n_bytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       line_done;
    } t_bundle;

endpackage

`default_nettype wire

>>> rtl/core/c_comment_string_stripper.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake         | payload
// --------+-----------+-------------------+----------------------------------------
// input   | in        | i_valid / o_ready | i_data  : in_byte, line_last
// output  | out       | o_valid / i_ready | o_data  : out_byte, byte_valid,
//         |           |                   |           line_done, run_last
//
// each source byte gives one to three output transfers: up to two cleaned bytes
// then a marker; the output side sends one per cycle while i_ready is high
// the first result passes the input register, then the result register, and is
// offered once the result register is free to take it
// reset (synchronous, active low) clears the modes, the hold and the line count
// a stalled output holds the result register; the input register is taken as
// soon as the last result of the previous byte is transferred

module c_comment_string_stripper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  csp_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output csp_pkg::t_out_item  o_data
);
    import csp_pkg::*;

    // input register
    t_in_item    r_in;
    logic        r_in_valid;

    // scanner state
    t_scan_state r_state;
    t_scan_state n_state;
    t_bundle     n_bundle;

    logic        out_free;
    logic        advance;

    // move the held byte on when the result register can take its bundle
    assign advance = r_in_valid && out_free;
    assign o_ready = !r_in_valid || out_free;

    csp_decide u_decide (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_bundle (n_bundle)
    );

    csp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_bundle (n_bundle),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    // modes, hold and line count update once per decided byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/csp_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module csp_decide (
    input  csp_pkg::t_scan_state i_state,
    input  csp_pkg::t_in_item    i_item,
    output csp_pkg::t_scan_state o_state,
    output csp_pkg::t_bundle     o_bundle
);
    import csp_pkg::*;

    typedef struct packed {
        t_scan_state st;
        t_bundle     bnd;
        logic        used;
    } t_acc;

    // append one byte unless the line is full
    function automatic t_acc put_b(t_acc a, logic [7:0] b);
        t_acc r;
        r = a;
        if (r.st.out_count < LINE_LIMIT) begin
            if (r.bnd.n_bytes == 2'd0) begin
                r.bnd.byte0 = b;
            end else begin
                r.bnd.byte1 = b;
            end
            r.bnd.n_bytes   = r.bnd.n_bytes + 2'd1;
            r.st.out_count  = r.st.out_count + 1'b1;
        end
        return r;
    endfunction

    // decide one byte, with the following byte when there is one
    function automatic t_acc decide(t_acc a, logic [7:0] cur, logic has_next,
                                    logic [7:0] nxt);
        t_acc r;
        r      = a;
        r.used = 1'b0;
        if (r.st.out_count >= LINE_LIMIT) begin
            r.st.skip_rest_of_line = 1'b1;
            r.used                 = 1'b1;
        end else if (r.st.in_block_comment) begin
            r = put_b(r, (cur == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE);
            if (cur == CH_STAR && has_next && nxt == CH_SLASH) begin
                r = put_b(r, CH_SPACE);
                r.st.in_block_comment = 1'b0;
                r.used                = 1'b1;
            end
        end else if (r.st.in_string_lit || r.st.in_char_lit) begin
            r = put_b(r, cur);
            if (cur == CH_BACKSLASH && has_next && r.st.out_count < LINE_LIMIT) begin
                r      = put_b(r, nxt);
                r.used = 1'b1;
            end else begin
                if (r.st.in_string_lit && cur == CH_DQUOTE) begin
                    r.st.in_string_lit = 1'b0;
                end
                if (r.st.in_char_lit && cur == CH_SQUOTE) begin
                    r.st.in_char_lit = 1'b0;
                end
            end
        end else if (cur == CH_SLASH && has_next && nxt == CH_STAR) begin
            r = put_b(r, CH_SPACE);
            r = put_b(r, CH_SPACE);
            r.st.in_block_comment = 1'b1;
            r.used                = 1'b1;
        end else if (cur == CH_SLASH && has_next && nxt == CH_SLASH) begin
            r.st.skip_rest_of_line = 1'b1;
            r.used                 = 1'b1;
        end else begin
            if (cur == CH_DQUOTE) begin
                r.st.in_string_lit = 1'b1;
            end else if (cur == CH_SQUOTE) begin
                r.st.in_char_lit = 1'b1;
            end
            r = put_b(r, cur);
        end
        return r;
    endfunction

    t_acc a0;
    t_acc a1;
    t_acc a2;

    always_comb begin
        a0           = '0;
        a0.st        = i_state;
        a1           = a0;
        // pair the held byte with the incoming one
        if (!a0.st.skip_rest_of_line) begin
            if (a0.st.held_valid) begin
                a1 = decide(a0, a0.st.held_byte, 1'b1, i_item.in_byte);
                a1.st.held_valid = 1'b0;
                a1.st.held_byte  = '0;
                if (!a1.used && !a1.st.skip_rest_of_line) begin
                    a1.st.held_byte  = i_item.in_byte;
                    a1.st.held_valid = 1'b1;
                end
            end else begin
                a1.st.held_byte  = i_item.in_byte;
                a1.st.held_valid = 1'b1;
            end
        end
        // line end flushes the hold and clears per-line modes
        a2 = a1;
        if (i_item.line_last) begin
            if (a1.st.held_valid && !a1.st.skip_rest_of_line) begin
                a2 = decide(a1, a1.st.held_byte, 1'b0, 8'h00);
            end
            a2.st.held_valid        = 1'b0;
            a2.st.held_byte         = '0;
            a2.st.in_string_lit     = 1'b0;
            a2.st.in_char_lit       = 1'b0;
            a2.st.skip_rest_of_line = 1'b0;
            a2.st.out_count         = '0;
        end
        a2.bnd.line_done = i_item.line_last;
        o_state  = a2.st;
        o_bundle = a2.bnd;
    end

endmodule

`default_nettype wire

>>> rtl/core/csp_out.sv
`timescale 1ns / 1ps
`default_nettype none

module csp_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  csp_pkg::t_bundle    i_bundle,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output csp_pkg::t_out_item  o_data
);
    import csp_pkg::*;

    t_bundle    r_bundle;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       is_byte;
    logic       is_last;

    assign is_byte = (r_idx < r_bundle.n_bytes);
    assign is_last = !is_byte;
    assign o_valid = r_busy;
    assign o_free  = !r_busy || (i_ready && is_last);

    always_comb begin
        o_data            = '0;
        o_data.byte_valid = is_byte;
        o_data.run_last   = is_last;
        o_data.line_done  = is_last && r_bundle.line_done;
        if (is_byte) begin
            o_data.out_byte = (r_idx == 2'd0) ? r_bundle.byte0 : r_bundle.byte1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

`default_nettype wire
